// ----- design/cdbd_pkg.sv -----
// shared constants, types and calendar table functions for the date difference core
package cdbd_pkg;

	localparam int unsigned MAX_YEAR_DEF = 9999;

	localparam int unsigned YEAR_W   = 14;
	localparam int unsigned MONTH_W  = 4;
	localparam int unsigned DAY_W    = 5;
	localparam int unsigned COUNT_W  = 22;
	// serial day numbers reach about 6.0e6 for the largest 14-bit year
	localparam int unsigned SERIAL_W = 23;
	// month offset plus day, at most 365
	localparam int unsigned OFF_W    = 10;
	// quotient by 100 of a year plus at most 399, at most 167
	localparam int unsigned QUOT_W   = 8;
	// compare width that holds any year limit up to 65535
	localparam int unsigned YCMP_W   = 17;

	// floor(x / 100) for x < 2**15 as (x * ceil(2**21 / 100)) >> 21
	localparam int unsigned DIV100_SHIFT = 21;
	localparam int unsigned DIV100_MUL   = (2 ** DIV100_SHIFT + 99) / 100;
	localparam int unsigned DIV100_PW    = 30;

	localparam int unsigned DAYS_PER_YEAR = 365;
	localparam int unsigned FEBRUARY      = 2;
	localparam int unsigned DECEMBER      = 12;

	// per-stage load enables handed to each lane
	typedef struct packed {
		logic en_s1;
		logic en_s2;
		logic en_s3;
	} cdbd_lane_en_t;

	// what one lane hands to the merge stage
	typedef struct packed {
		logic                ok;
		logic [SERIAL_W-1:0] serial;
	} cdbd_lane_res_t;

	function automatic logic [QUOT_W-1:0] div100(input logic [YEAR_W:0] x);
		logic [DIV100_PW-1:0] prod;
		prod = DIV100_PW'(x) * DIV100_PW'(DIV100_MUL);
		return prod[DIV100_SHIFT +: QUOT_W];
	endfunction

	function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m);
		logic [DAY_W-1:0] len;
		unique case (m)
			4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
			4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
			4'd2:                                       len = 5'd28;
			default:                                    len = 5'd0;
		endcase
		return len;
	endfunction

	function automatic logic [OFF_W-1:0] days_before(input logic [MONTH_W-1:0] m);
		logic [OFF_W-1:0] n;
		unique case (m)
			4'd1:    n = 10'd0;
			4'd2:    n = 10'd31;
			4'd3:    n = 10'd59;
			4'd4:    n = 10'd90;
			4'd5:    n = 10'd120;
			4'd6:    n = 10'd151;
			4'd7:    n = 10'd181;
			4'd8:    n = 10'd212;
			4'd9:    n = 10'd243;
			4'd10:   n = 10'd273;
			4'd11:   n = 10'd304;
			4'd12:   n = 10'd334;
			default: n = 10'd0;
		endcase
		return n;
	endfunction

endpackage

// ----- design/calendar_days_between_dates_core.sv -----
// top level of the gregorian date difference core
// Takes two dates (year, month, day) per input beat and returns one result beat with
// the absolute number of days between them, or date_error set and a zero count when
// either date is not a valid Gregorian date (year above MAX_YEAR, month outside 1..12,
// day zero or past the month length with the 4/100/400 leap rule; year 0 is a leap year).
// Each date runs through its own lane that checks it and forms a serial day number
// counted from 0000-01-01 by closed form with constant divisors; a merge stage then
// takes the difference. A beat passes three lane stages, then the merge register. A new
// date pair is taken every cycle unless a result held on out_ready backs up the pipe:
// each stage holds its own valid bit, so a bubble anywhere is filled even while a finished
// result waits on out_ready. Nothing is kept between items and there is no configuration.
module calendar_days_between_dates_core #(
	parameter int unsigned MAX_YEAR = cdbd_pkg::MAX_YEAR_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [cdbd_pkg::YEAR_W-1:0]       year_a,
	input  logic [cdbd_pkg::MONTH_W-1:0]      month_a,
	input  logic [cdbd_pkg::DAY_W-1:0]        day_a,
	input  logic [cdbd_pkg::YEAR_W-1:0]       year_b,
	input  logic [cdbd_pkg::MONTH_W-1:0]      month_b,
	input  logic [cdbd_pkg::DAY_W-1:0]        day_b,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [cdbd_pkg::COUNT_W-1:0]      day_count,
	output logic                              date_error
);
	import cdbd_pkg::*;

	// per-stage occupancy
	logic valid_s1, valid_s2, valid_s3, valid_s4;
	// a stage can load when it is empty or its content moves on this cycle
	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4;
	cdbd_lane_en_t lane_en;
	logic          merge_en;
	cdbd_lane_res_t res_a, res_b;

	assign rdy_s4 = !valid_s4 || out_ready;
	assign rdy_s3 = !valid_s3 || rdy_s4;
	assign rdy_s2 = !valid_s2 || rdy_s3;
	assign rdy_s1 = !valid_s1 || rdy_s2;

	assign in_ready  = rdy_s1;
	assign out_valid = valid_s4;

	// payload registers load only when a real beat enters the stage
	assign lane_en.en_s1 = in_valid && rdy_s1;
	assign lane_en.en_s2 = valid_s1 && rdy_s2;
	assign lane_en.en_s3 = valid_s2 && rdy_s3;
	assign merge_en      = valid_s3 && rdy_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (rdy_s1) valid_s1 <= in_valid;
			if (rdy_s2) valid_s2 <= valid_s1;
			if (rdy_s3) valid_s3 <= valid_s2;
			if (rdy_s4) valid_s4 <= valid_s3;
		end
	end

	// lane for the first date
	cdbd_lane #(
		.MAX_YEAR(MAX_YEAR)
	) u_lane_a (
		.clk  (clk),
		.en   (lane_en),
		.year (year_a),
		.month(month_a),
		.day  (day_a),
		.res  (res_a)
	);

	// lane for the second date
	cdbd_lane #(
		.MAX_YEAR(MAX_YEAR)
	) u_lane_b (
		.clk  (clk),
		.en   (lane_en),
		.year (year_b),
		.month(month_b),
		.day  (day_b),
		.res  (res_b)
	);

	// difference and error flag, also the output register
	cdbd_merge u_merge (
		.clk       (clk),
		.en        (merge_en),
		.res_a     (res_a),
		.res_b     (res_b),
		.day_count (day_count),
		.date_error(date_error)
	);

	// an error beat always carries a zero count
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && date_error) |-> (day_count == '0))
		else $error("error beat with nonzero day count");

	// an accepted input beat occupies stage one on the next cycle
	a_in_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> valid_s1)
		else $error("accepted beat lost at stage one");

	// a beat leaving the last lane stage shows up at the output next cycle
	a_merge_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s3 && rdy_s4) |=> out_valid)
		else $error("beat lost between lanes and merge stage");

endmodule

// ----- design/cdbd_lane.sv -----
// one date lane: validity check and serial day number, three stages
module cdbd_lane #(
	parameter int unsigned MAX_YEAR = cdbd_pkg::MAX_YEAR_DEF
) (
	input  logic                              clk,
	input  cdbd_pkg::cdbd_lane_en_t           en,
	input  logic [cdbd_pkg::YEAR_W-1:0]       year,
	input  logic [cdbd_pkg::MONTH_W-1:0]      month,
	input  logic [cdbd_pkg::DAY_W-1:0]        day,
	output cdbd_pkg::cdbd_lane_res_t          res
);
	import cdbd_pkg::*;

	// stage 1: constant multiplies
	logic [YEAR_W-1:0]   year_s1;
	logic [MONTH_W-1:0]  month_s1;
	logic [DAY_W-1:0]    day_s1;
	logic [SERIAL_W-1:0] y365_s1;
	logic [QUOT_W-1:0]   q100_s1;
	logic [QUOT_W-1:0]   qc100_s1;
	logic [QUOT_W-1:0]   qc400_s1;

	always_ff @(posedge clk) begin
		if (en.en_s1) begin
			year_s1  <= year;
			month_s1 <= month;
			day_s1   <= day;
			y365_s1  <= SERIAL_W'(year) * SERIAL_W'(DAYS_PER_YEAR);
			q100_s1  <= div100({1'b0, year});
			qc100_s1 <= div100({1'b0, year} + (YEAR_W+1)'(99));
			// ceil(y/400) = floor(floor((y+399)/100)/4)
			qc400_s1 <= div100({1'b0, year} + (YEAR_W+1)'(399));
		end
	end

	// stage 2: leap rule, validity, year base and month offset
	logic [YEAR_W-1:0]   rem100;
	logic                leap;
	logic [DAY_W-1:0]    len;
	logic                ok;
	logic [SERIAL_W-1:0] base;
	logic [OFF_W-1:0]    off;

	always_comb begin
		rem100 = year_s1 - YEAR_W'(YEAR_W'(q100_s1) * YEAR_W'(100));
		// divisible by 4 and not by 100, or by 400 (then y/100 is divisible by 4)
		leap   = (year_s1[1:0] == 2'b00) && ((rem100 != '0) || (q100_s1[1:0] == 2'b00));
		len    = month_len(month_s1);
		if (leap && (month_s1 == MONTH_W'(FEBRUARY))) begin
			len = len + DAY_W'(1);
		end
		ok     = ({(YCMP_W-YEAR_W)'(0), year_s1} <= YCMP_W'(MAX_YEAR))
		         && (month_s1 != '0) && (month_s1 <= MONTH_W'(DECEMBER))
		         && (day_s1 != '0) && (day_s1 <= len);
		base   = y365_s1
		         + SERIAL_W'(({1'b0, year_s1} + (YEAR_W+1)'(3)) >> 2)
		         - SERIAL_W'(qc100_s1)
		         + SERIAL_W'(qc400_s1 >> 2);
		off    = days_before(month_s1) + OFF_W'(day_s1) - OFF_W'(1);
		if (leap && (month_s1 > MONTH_W'(FEBRUARY))) begin
			off = off + OFF_W'(1);
		end
	end

	logic                ok_s2;
	logic [SERIAL_W-1:0] base_s2;
	logic [OFF_W-1:0]    off_s2;

	always_ff @(posedge clk) begin
		if (en.en_s2) begin
			ok_s2   <= ok;
			base_s2 <= base;
			off_s2  <= off;
		end
	end

	// stage 3: final serial day number
	logic                ok_s3;
	logic [SERIAL_W-1:0] serial_s3;

	always_ff @(posedge clk) begin
		if (en.en_s3) begin
			ok_s3     <= ok_s2;
			serial_s3 <= base_s2 + SERIAL_W'(off_s2);
		end
	end

	assign res.ok     = ok_s3;
	assign res.serial = serial_s3;

endmodule

// ----- design/cdbd_merge.sv -----
// merge stage: absolute difference of the two lanes and the error flag
module cdbd_merge (
	input  logic                          clk,
	input  logic                          en,
	input  cdbd_pkg::cdbd_lane_res_t      res_a,
	input  cdbd_pkg::cdbd_lane_res_t      res_b,
	output logic [cdbd_pkg::COUNT_W-1:0]  day_count,
	output logic                          date_error
);
	import cdbd_pkg::*;

	logic [SERIAL_W-1:0] diff;
	logic                err;
	logic [COUNT_W-1:0]  count_s4;
	logic                err_s4;

	always_comb begin
		diff = (res_a.serial > res_b.serial) ? (res_a.serial - res_b.serial)
		                                     : (res_b.serial - res_a.serial);
		err  = !(res_a.ok && res_b.ok);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			err_s4   <= err;
			count_s4 <= err ? '0 : diff[COUNT_W-1:0];
		end
	end

	assign day_count  = count_s4;
	assign date_error = err_s4;

endmodule

// ----- dv/tb_top.sv -----
// self-checking testbench for the gregorian date difference core
module tb_top;
	import cdbd_pkg::*;

	// largest year the core accepts, left at its default
	localparam int unsigned LAST_YEAR = MAX_YEAR_DEF;
	// several times the slowest correct run: ~725 beats, each with idle cycles drawn
	// at random on both sides plus the pipe, plus the long receiver hold-off
	localparam int unsigned CYCLE_LIMIT = 200000;
	localparam int unsigned RANDOM_PAIRS = 700;
	// receiver hold-off, long enough to back the pipe up into in_ready
	localparam int unsigned HOLD_AT_BEAT = 300;
	localparam int unsigned HOLD_CYCLES = 300;
	// cycles after the last result, more than a pass through the four stages of the pipe
	localparam int unsigned DRAIN_CYCLES = 8;

	// one date pair waiting to be sent, with the idle cycles before it
	typedef struct {
		logic [YEAR_W-1:0]  ya;
		logic [MONTH_W-1:0] ma;
		logic [DAY_W-1:0]   da;
		logic [YEAR_W-1:0]  yb;
		logic [MONTH_W-1:0] mb;
		logic [DAY_W-1:0]   db;
		int unsigned        gap;
	} date_pair_t;

	// what the core should return for one date pair
	typedef struct {
		logic [COUNT_W-1:0] count;
		logic               err;
	} day_gap_t;

	logic                clk        = 1'b0;
	logic                arst_n     = 1'b0;
	logic                in_valid   = 1'b0;
	logic                in_ready;
	logic [YEAR_W-1:0]   year_a     = '0;
	logic [MONTH_W-1:0]  month_a    = '0;
	logic [DAY_W-1:0]    day_a      = '0;
	logic [YEAR_W-1:0]   year_b     = '0;
	logic [MONTH_W-1:0]  month_b    = '0;
	logic [DAY_W-1:0]    day_b      = '0;
	logic                out_valid;
	logic                out_ready  = 1'b0;
	logic [COUNT_W-1:0]  day_count;
	logic                date_error;

	date_pair_t  date_pairs[$];     // pairs not yet offered to the core
	day_gap_t    pending_gaps[$];   // predicted results, oldest first
	date_pair_t  cur_pair;
	day_gap_t    want;
	int unsigned pairs_queued = 0;
	int unsigned send_wait    = 0;
	int unsigned recv_wait    = 0;
	int unsigned hold_left    = 0;
	bit          hold_done    = 1'b0;
	int unsigned beats_in     = 0;
	int unsigned beats_out    = 0;
	int unsigned mismatches   = 0;
	int unsigned cycles       = 0;

	calendar_days_between_dates_core uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.year_a     (year_a),
		.month_a    (month_a),
		.day_a      (day_a),
		.year_b     (year_b),
		.month_b    (month_b),
		.day_b      (day_b),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.day_count  (day_count),
		.date_error (date_error)
	);

	// ---------------------------------------------------------------
	// calendar arithmetic for the prediction
	// ---------------------------------------------------------------

	// 4/100/400 rule, year 0 is divisible by 400 so it is a leap year
	function automatic bit is_leap(input int unsigned y);
		return ((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0;
	endfunction

	// zero for a month outside 1..12, which then fails any day check
	function automatic int unsigned days_in_month(input int unsigned y, input int unsigned m);
		case (m)
			2:                         return is_leap(y) ? 29 : 28;
			4, 6, 9, 11:               return 30;
			1, 3, 5, 7, 8, 10, 12:     return 31;
			default:                   return 0;
		endcase
	endfunction

	function automatic bit date_valid(input int unsigned y, input int unsigned m,
			input int unsigned d);
		return y <= LAST_YEAR && m >= 1 && m <= 12 && d >= 1 && d <= days_in_month(y, m);
	endfunction

	// days since 0000-01-01; leap days of the years before y are counted
	// by rounding up, which takes year 0 itself into account
	function automatic int unsigned day_number(input int unsigned y, input int unsigned m,
			input int unsigned d);
		int unsigned n;
		n = 365 * y + (y + 3) / 4 - (y + 99) / 100 + (y + 399) / 400;
		for (int unsigned k = 1; k < m; k++)
			n += days_in_month(y, k);
		return n + d - 1;
	endfunction

	function automatic day_gap_t calc_day_gap(input date_pair_t p);
		day_gap_t    r;
		int unsigned na;
		int unsigned nb;
		r.err   = !(date_valid(p.ya, p.ma, p.da) && date_valid(p.yb, p.mb, p.db));
		r.count = '0;
		if (!r.err) begin
			na      = day_number(p.ya, p.ma, p.da);
			nb      = day_number(p.yb, p.mb, p.db);
			r.count = COUNT_W'((na > nb) ? (na - nb) : (nb - na));
		end
		return r;
	endfunction

	// ---------------------------------------------------------------
	// stimulus building
	// ---------------------------------------------------------------

	// every third block of 60 pairs is sent back to back with no idling
	task automatic add_pair(input int unsigned ya, input int unsigned ma, input int unsigned da,
			input int unsigned yb, input int unsigned mb, input int unsigned db);
		date_pair_t p;
		p.ya  = YEAR_W'(ya);
		p.ma  = MONTH_W'(ma);
		p.da  = DAY_W'(da);
		p.yb  = YEAR_W'(yb);
		p.mb  = MONTH_W'(mb);
		p.db  = DAY_W'(db);
		p.gap = ((pairs_queued / 60) % 3 == 1) ? 0 : $urandom_range(13, 0);
		date_pairs.push_back(p);
		pairs_queued++;
	endtask

	// a valid date, leaning towards century years, the ends of the year
	// range and the last day of the month
	task automatic pick_date(output int unsigned y, output int unsigned m,
			output int unsigned d);
		case ($urandom_range(3, 0))
			0:       y = $urandom_range(LAST_YEAR, 0);
			1:       y = 100 * $urandom_range(99, 0) + $urandom_range(4, 0);
			2:       y = $urandom_range(LAST_YEAR, LAST_YEAR - 9);
			default: y = $urandom_range(10, 0);
		endcase
		m = $urandom_range(12, 1);
		d = ($urandom_range(3, 0) == 0) ? days_in_month(y, m)
			: $urandom_range(days_in_month(y, m), 1);
	endtask

	// ---------------------------------------------------------------
	// clock
	// ---------------------------------------------------------------

	initial begin
		forever #2 clk = ~clk;
	end

	// ---------------------------------------------------------------
	// driver: one date pair per input beat, idle cycles drawn per pair
	// ---------------------------------------------------------------

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid  <= 1'b0;
			send_wait = 0;
		end else begin
			// predict at the beat, from the payload the core actually took
			if (in_valid && in_ready) begin
				cur_pair.ya = year_a;
				cur_pair.ma = month_a;
				cur_pair.da = day_a;
				cur_pair.yb = year_b;
				cur_pair.mb = month_b;
				cur_pair.db = day_b;
				pending_gaps.push_back(calc_day_gap(cur_pair));
				beats_in++;
			end
			// valid and payload only move once the previous beat is taken
			if (!in_valid || in_ready) begin
				if (date_pairs.size() != 0 && send_wait >= date_pairs[0].gap) begin
					cur_pair  = date_pairs.pop_front();
					year_a    <= cur_pair.ya;
					month_a   <= cur_pair.ma;
					day_a     <= cur_pair.da;
					year_b    <= cur_pair.yb;
					month_b   <= cur_pair.mb;
					day_b     <= cur_pair.db;
					in_valid  <= 1'b1;
					send_wait = 0;
				end else begin
					in_valid <= 1'b0;
					if (date_pairs.size() != 0)
						send_wait++;
				end
			end
		end
	end

	// ---------------------------------------------------------------
	// monitor: checks each result beat, stalls drawn per result
	// ---------------------------------------------------------------

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			recv_wait = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (pending_gaps.size() == 0) begin
					$display("%0t: unexpected result beat, expected none, actual count %0d error %0b",
						$time, day_count, date_error);
					mismatches++;
				end else begin
					want = pending_gaps.pop_front();
					if (day_count !== want.count) begin
						$display("%0t: day_count mismatch, expected %0d, actual %0d",
							$time, want.count, day_count);
						mismatches++;
					end
					if (date_error !== want.err) begin
						$display("%0t: date_error mismatch, expected %0b, actual %0b",
							$time, want.err, date_error);
						mismatches++;
					end
				end
				beats_out++;
				// a block of 60 results out of every 180 goes without stalls
				recv_wait = ((beats_out / 60) % 3 == 2) ? 0 : $urandom_range(13, 0);
			end
			// one long hold-off while the sender keeps offering, so the pipe
			// fills and in_ready drops
			if (!hold_done && beats_in >= HOLD_AT_BEAT) begin
				hold_left = HOLD_CYCLES;
				hold_done = 1'b1;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (recv_wait > 0) begin
				recv_wait--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// ---------------------------------------------------------------
	// watchdog
	// ---------------------------------------------------------------

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// ---------------------------------------------------------------
	// stimulus and end of run
	// ---------------------------------------------------------------

	initial begin
		int unsigned ya, ma, da, yb, mb, db, pick;

		// directed pairs
		add_pair(2000, 2, 29, 2000, 2, 29);             // equal dates
		add_pair(0, 1, 1, LAST_YEAR, 12, 31);           // widest span
		add_pair(LAST_YEAR, 12, 31, 0, 1, 1);           // same, reversed
		add_pair(0, 2, 29, 0, 3, 1);                    // year 0 is leap
		add_pair(1900, 2, 29, 1900, 3, 1);              // century, not leap
		add_pair(2000, 2, 29, 1900, 3, 1);              // 400 rule
		add_pair(2023, 2, 29, 2023, 3, 1);              // common year February
		add_pair(2024, 2, 29, 2023, 12, 31);
		add_pair(2024, 2, 30, 2024, 2, 1);              // day past leap February
		add_pair(LAST_YEAR + 1, 1, 1, 2000, 1, 1);      // year just past the limit
		add_pair(2000, 1, 1, 16383, 1, 1);              // largest year field
		add_pair(2000, 0, 1, 2000, 1, 1);               // month zero
		add_pair(2000, 1, 1, 2000, 13, 1);              // month thirteen
		add_pair(2000, 15, 1, 2000, 1, 1);              // largest month field
		add_pair(2000, 1, 0, 2000, 1, 1);               // day zero
		add_pair(2000, 4, 31, 2000, 5, 1);              // day past a 30-day month
		add_pair(2000, 12, 31, 2001, 1, 1);
		add_pair(16383, 15, 31, 16383, 15, 31);         // all field bits set
		add_pair(0, 0, 0, 0, 0, 0);                     // all field bits clear
		add_pair(LAST_YEAR, 12, 31, LAST_YEAR, 12, 30);
		add_pair(1600, 3, 1, 1700, 2, 28);
		add_pair(0, 1, 1, 0, 1, 1);

		// random pairs: mostly valid dates, some with one field broken,
		// the rest with every field random over its whole width
		for (int unsigned i = 0; i < RANDOM_PAIRS; i++) begin
			pick_date(ya, ma, da);
			pick_date(yb, mb, db);
			if ($urandom_range(9, 0) == 0) begin
				yb = ya;
				mb = ma;
				db = da;
			end
			pick = $urandom_range(99, 0);
			if (pick >= 70 && pick < 88) begin
				case ($urandom_range(5, 0))
					0:       ya = $urandom_range(16383, 0);
					1:       ma = $urandom_range(15, 0);
					2:       da = $urandom_range(31, 0);
					3:       yb = $urandom_range(16383, 0);
					4:       mb = $urandom_range(15, 0);
					default: db = $urandom_range(31, 0);
				endcase
			end else if (pick >= 88) begin
				ya = $urandom_range(16383, 0);
				ma = $urandom_range(15, 0);
				da = $urandom_range(31, 0);
				yb = $urandom_range(16383, 0);
				mb = $urandom_range(15, 0);
				db = $urandom_range(31, 0);
			end
			add_pair(ya, ma, da, yb, mb, db);
		end

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// every pair offered and taken, then every result back
		while (date_pairs.size() != 0 || in_valid)
			@(posedge clk);
		while (pending_gaps.size() != 0)
			@(posedge clk);
		// catch any stray result beat
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

// ----- files.f -----
design/cdbd_pkg.sv
design/cdbd_lane.sv
design/cdbd_merge.sv
design/calendar_days_between_dates_core.sv
dv/tb_top.sv
